// ===== sv/dxf_ascii_group_pair_parser_top_defines.svh =====
// Assertion macros shared by the group pair parser RTL.
// No dependencies; files that check their own logic include this header.
`ifndef DXF_ASCII_GROUP_PAIR_PARSER_TOP_DEFINES_SVH
`define DXF_ASCII_GROUP_PAIR_PARSER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Plain clocked property, disabled while reset is asserted
`define DGP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Same-cycle implication
`define DGP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DGP_ASSERT(label, clk, rstn, prop, msg)
`define DGP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/dgp_pkg.sv =====
// Shared types and constants for the group code / value pair parser.
// No dependencies; used by every module of the block.
package dgp_pkg;

    // Default longest line, in bytes
    localparam int MAX_LINE_DEFAULT = 1048576;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 2;
    localparam int ACC_W   = 17;
    localparam int MAC_W   = 21;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_VALUE_LIMIT   = 1'b0;
    localparam logic REG_SKIP_COMMENTS = 1'b1;
    localparam logic [LEN_W-1:0] VALUE_LIMIT_RESET = 16'd256;
    localparam logic SKIP_COMMENTS_RESET = 1'b1;

    // Characters
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'd11;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    localparam logic [ACC_W-1:0]  COMMENT_CODE = 17'd999;
    localparam logic [ACC_W-1:0]  ACC_SAT      = 17'd32768;
    localparam logic [CODE_W-1:0] CODE_POS_MAX = 16'd32767;

    // Configuration seen by the parser
    typedef struct packed {
        logic [LEN_W-1:0] value_limit;
        logic             skip_comments;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [CODE_W-1:0] group_code;
        logic [BYTE_W-1:0]        value_byte;
        logic [LEN_W-1:0]         value_length;
        logic                     truncated;
    } res_t;

endpackage

// ===== sv/dxf_ascii_group_pair_parser_top.sv =====
// Top level of the group code / value pair parser.
// Depends on dgp_pkg, dgp_cfg, dgp_parse and dgp_outq.
//
// Reads a text byte stream, one byte per item, as alternating code and value
// lines (CR, LF, CRLF or LFCR endings). Takes one byte every cycle: the parser
// handles each byte as it is accepted and its result, if any, lands in
// a two-entry output buffer, so s_tready only drops when that buffer is full.
// Results are registered in that buffer and offered on the m_ side from there.
// Results: kind 0 carries one value byte, kind 1 closes a pair with its
// length and truncation flag, kind 2 marks end of data or an overlong line.
// Configuration (value_limit at 0x0, skip_comments at 0x4) may be written
// only while the block is idle.
module dxf_ascii_group_pair_parser_top #(
    parameter int MAX_LINE = dgp_pkg::MAX_LINE_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dgp_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] stream_end
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] group_code, [23:16] value_byte, [39:24] value_length, [40] truncated
    output logic [dgp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [dgp_pkg::KIND_W-1:0]       m_tuser,  // [1:0] kind
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dgp_pkg::CFG_AW-1:0]       paddr,
    input  logic [dgp_pkg::CFG_DW-1:0]       pwdata,
    output logic [dgp_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);

    dgp_pkg::cfg_t cfg;
    dgp_pkg::res_t res;
    dgp_pkg::res_t out_res;
    logic          res_vld;
    logic          in_fire;
    logic          q_not_full;

    assign s_tready = q_not_full;
    assign in_fire  = s_tvalid & s_tready;

    dgp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dgp_parse #(
        .MAX_LINE (MAX_LINE)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .data_byte  (s_tdata[dgp_pkg::BYTE_W-1:0]),
        .stream_end (s_tuser),
        .cfg        (cfg),
        .res_vld    (res_vld),
        .res        (res)
    );

    dgp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire & res_vld),
        .push_data (res),
        .not_full  (q_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack result fields, lowest first
    assign m_tdata = {7'b0, out_res.truncated, out_res.value_length,
                      out_res.value_byte, out_res.group_code};
    assign m_tuser = out_res.kind;

endmodule

// ===== sv/dgp_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on dgp_pkg.
module dgp_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dgp_pkg::CFG_AW-1:0]  paddr,
    input  logic [dgp_pkg::CFG_DW-1:0]  pwdata,
    output logic [dgp_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output dgp_pkg::cfg_t               cfg
);

    logic [dgp_pkg::LEN_W-1:0] value_limit_reg;
    logic                      skip_comments_reg;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // registers sit at 4-byte spacing
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_limit_reg   <= dgp_pkg::VALUE_LIMIT_RESET;
            skip_comments_reg <= dgp_pkg::SKIP_COMMENTS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                dgp_pkg::REG_VALUE_LIMIT:   value_limit_reg   <= pwdata[dgp_pkg::LEN_W-1:0];
                dgp_pkg::REG_SKIP_COMMENTS: skip_comments_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            dgp_pkg::REG_VALUE_LIMIT:   prdata = dgp_pkg::CFG_DW'(value_limit_reg);
            dgp_pkg::REG_SKIP_COMMENTS: prdata = dgp_pkg::CFG_DW'(skip_comments_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.value_limit   = value_limit_reg;
    assign cfg.skip_comments = skip_comments_reg;

endmodule

// ===== sv/dgp_parse.sv =====
// Per-byte parser: line splitting, code parsing, value passing, record close.
// Depends on dgp_pkg and the assertion macro header.
`include "dxf_ascii_group_pair_parser_top_defines.svh"
module dgp_parse #(
    parameter int MAX_LINE = dgp_pkg::MAX_LINE_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [dgp_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        stream_end,
    input  dgp_pkg::cfg_t               cfg,
    output logic                        res_vld,
    output dgp_pkg::res_t               res
);

    localparam int LLW = $clog2(MAX_LINE + 1);

    // phase codes
    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_HALT  = 2'd2;
    // code parse codes
    localparam logic [1:0] CP_START  = 2'd0;
    localparam logic [1:0] CP_DIGITS = 2'd1;
    localparam logic [1:0] CP_DONE   = 2'd2;
    // pending terminator codes
    localparam logic [1:0] PT_NONE = 2'd0;
    localparam logic [1:0] PT_CR   = 2'd1;
    localparam logic [1:0] PT_LF   = 2'd2;

    logic [1:0]                phase_reg, phase_next;
    logic [dgp_pkg::ACC_W-1:0] accum_reg, accum_next;
    logic                      neg_reg, neg_next;
    logic [1:0]                cps_reg, cps_next;
    logic [1:0]                pend_reg, pend_next;
    logic [LLW-1:0]            line_len_reg, line_len_next;
    logic [dgp_pkg::LEN_W-1:0] stored_reg, stored_next;
    logic                      trunc_reg, trunc_next;

    logic                      is_digit;
    logic                      is_blank;
    logic                      is_term;
    logic                      swallow;
    logic                      is_comment;
    logic [dgp_pkg::MAC_W-1:0] mac;
    logic [dgp_pkg::ACC_W-1:0] mac_sat;
    logic [dgp_pkg::CODE_W-1:0] code_val;

    // byte classes
    assign is_digit = (data_byte >= dgp_pkg::CH_ZERO) && (data_byte <= dgp_pkg::CH_NINE);
    assign is_blank = (data_byte == dgp_pkg::CH_SP) || (data_byte == dgp_pkg::CH_TAB) ||
                      (data_byte == dgp_pkg::CH_VT) || (data_byte == dgp_pkg::CH_FF);
    assign is_term  = (data_byte == dgp_pkg::CH_CR) || (data_byte == dgp_pkg::CH_LF);
    assign swallow  = ((pend_reg == PT_CR) && (data_byte == dgp_pkg::CH_LF)) ||
                      ((pend_reg == PT_LF) && (data_byte == dgp_pkg::CH_CR));

    // comment pair test and saturated code
    assign is_comment = cfg.skip_comments && !neg_reg && (accum_reg == dgp_pkg::COMMENT_CODE);
    assign code_val   = neg_reg ? dgp_pkg::CODE_W'(17'd65536 - accum_reg)
                      : ((accum_reg > dgp_pkg::ACC_W'(dgp_pkg::CODE_POS_MAX))
                         ? dgp_pkg::CODE_POS_MAX : accum_reg[dgp_pkg::CODE_W-1:0]);

    // decimal accumulate, saturating at 32768
    assign mac     = dgp_pkg::MAC_W'(accum_reg) * dgp_pkg::MAC_W'(10)
                   + dgp_pkg::MAC_W'(data_byte[3:0]);
    assign mac_sat = (mac > dgp_pkg::MAC_W'(dgp_pkg::ACC_SAT))
                   ? dgp_pkg::ACC_SAT : mac[dgp_pkg::ACC_W-1:0];

    // next state and result for one item
    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        neg_next      = neg_reg;
        cps_next      = cps_reg;
        pend_next     = pend_reg;
        line_len_next = line_len_reg;
        stored_next   = stored_reg;
        trunc_next    = trunc_reg;
        res_vld       = 1'b0;
        res           = '0;

        if (stream_end) begin
            phase_next    = PH_CODE;
            accum_next    = '0;
            neg_next      = 1'b0;
            cps_next      = CP_START;
            pend_next     = PT_NONE;
            line_len_next = '0;
            stored_next   = '0;
            trunc_next    = 1'b0;
            res_vld       = (phase_reg != PH_HALT);
            res.kind       = dgp_pkg::KIND_END;
            res.group_code = '1;
        end else if (phase_reg == PH_HALT) begin
            // halted: drop data bytes
        end else if (swallow) begin
            pend_next = PT_NONE;
        end else if (is_term) begin
            pend_next     = (data_byte == dgp_pkg::CH_CR) ? PT_CR : PT_LF;
            line_len_next = '0;
            stored_next   = '0;
            trunc_next    = 1'b0;
            if (phase_reg == PH_CODE) begin
                phase_next = PH_VALUE;
            end else begin
                phase_next = PH_CODE;
                accum_next = '0;
                neg_next   = 1'b0;
                cps_next   = CP_START;
                res_vld    = !is_comment;
                res.kind         = dgp_pkg::KIND_RECORD;
                res.group_code   = code_val;
                res.value_length = stored_reg;
                res.truncated    = trunc_reg;
            end
        end else if (line_len_reg >= LLW'(MAX_LINE)) begin
            pend_next      = PT_NONE;
            phase_next     = PH_HALT;
            res_vld        = 1'b1;
            res.kind       = dgp_pkg::KIND_END;
            res.group_code = '1;
        end else begin
            pend_next     = PT_NONE;
            line_len_next = line_len_reg + LLW'(1);
            if (phase_reg == PH_CODE) begin
                // atoi-style code parse
                priority if (cps_reg == CP_START && is_blank) begin
                end else if (cps_reg == CP_START && data_byte == dgp_pkg::CH_PLUS) begin
                    cps_next = CP_DIGITS;
                end else if (cps_reg == CP_START && data_byte == dgp_pkg::CH_MINUS) begin
                    neg_next = 1'b1;
                    cps_next = CP_DIGITS;
                end else if ((cps_reg == CP_START || cps_reg == CP_DIGITS) && is_digit) begin
                    cps_next   = CP_DIGITS;
                    accum_next = mac_sat;
                end else begin
                    cps_next = CP_DONE;
                end
            end else if (!is_comment) begin
                if (stored_reg < cfg.value_limit) begin
                    stored_next    = stored_reg + dgp_pkg::LEN_W'(1);
                    res_vld        = 1'b1;
                    res.kind       = dgp_pkg::KIND_VALUE;
                    res.group_code = code_val;
                    res.value_byte = data_byte;
                end else begin
                    trunc_next = 1'b1;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CODE;
            accum_reg    <= '0;
            neg_reg      <= 1'b0;
            cps_reg      <= CP_START;
            pend_reg     <= PT_NONE;
            line_len_reg <= '0;
            stored_reg   <= '0;
            trunc_reg    <= 1'b0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            neg_reg      <= neg_next;
            cps_reg      <= cps_next;
            pend_reg     <= pend_next;
            line_len_reg <= line_len_next;
            stored_reg   <= stored_next;
            trunc_reg    <= trunc_next;
        end
    end

    // checks
    `DGP_ASSERT_IMP(a_vbyte_only_value, aclk, aresetn,
        in_fire && res_vld && res.kind != dgp_pkg::KIND_VALUE, res.value_byte == '0,
        "value byte set on a non-value item")
    `DGP_ASSERT_IMP(a_halt_silent, aclk, aresetn,
        in_fire && phase_reg == PH_HALT && !stream_end, !res_vld,
        "result produced while halted")
    `DGP_ASSERT_IMP(a_value_counts, aclk, aresetn,
        in_fire && res_vld && res.kind == dgp_pkg::KIND_VALUE,
        stored_next == stored_reg + dgp_pkg::LEN_W'(1),
        "value item without count advance")

endmodule

// ===== sv/dgp_outq.sv =====
// Two-entry result buffer between the parser and the output channel.
// Depends on dgp_pkg.
module dgp_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dgp_pkg::res_t push_data,
    output logic          not_full,
    output logic          out_valid,
    input  logic          out_ready,
    output dgp_pkg::res_t out_data
);

    dgp_pkg::res_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          pop;

    assign not_full  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== tb/sv/dxf_ascii_group_pair_parser_top_tb.sv =====
// Self-checking testbench for the group code / value pair parser top level.
// Depends on dgp_pkg and dxf_ascii_group_pair_parser_top; drives the byte stream
// and APB port, predicts every result item and checks it against the m_ stream.
module dxf_ascii_group_pair_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Line limit given to the block under test
    localparam int LINE_MAX      = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 80;
    localparam int NUM_PHASES    = 5;

    localparam logic [dgp_pkg::CFG_AW-1:0] ADDR_VALUE_LIMIT   =
        {dgp_pkg::REG_VALUE_LIMIT, 2'b00};
    localparam logic [dgp_pkg::CFG_AW-1:0] ADDR_SKIP_COMMENTS =
        {dgp_pkg::REG_SKIP_COMMENTS, 2'b00};

    typedef enum logic [1:0] {LN_CODE, LN_VALUE, LN_HALTED} line_t;
    typedef enum logic [1:0] {TERM_NONE, TERM_CR, TERM_LF} term_t;
    typedef enum logic [1:0] {PS_LEAD, PS_DIGITS, PS_DONE} pstate_t;

    typedef struct packed {
        logic [dgp_pkg::BYTE_W-1:0] data;
        logic                       eos;
        logic                       typed;
        dgp_pkg::res_t              want;
    } stim_row_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dgp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte
    logic                            s_tuser  = 1'b0; // [0] stream_end
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [15:0] group_code, [23:16] value_byte, [39:24] value_length, [40] truncated
    logic [dgp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [dgp_pkg::KIND_W-1:0]      m_tuser;  // [1:0] kind
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [dgp_pkg::CFG_AW-1:0]      paddr   = '0;
    logic [dgp_pkg::CFG_DW-1:0]      pwdata  = '0;
    logic [dgp_pkg::CFG_DW-1:0]      prdata;
    logic                            pready;

    dxf_ascii_group_pair_parser_top #(
        .MAX_LINE (LINE_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the parser state and its registers
    logic [dgp_pkg::LEN_W-1:0]  cfg_value_limit;
    logic                       cfg_skip;
    line_t                      pr_phase;
    logic [dgp_pkg::ACC_W-1:0]  pr_accum;
    logic                       pr_neg;
    pstate_t                    pr_pstate;
    term_t                      pr_term;
    int                         pr_linelen;
    logic [dgp_pkg::LEN_W-1:0]  pr_stored;
    logic                       pr_trunc;

    dgp_pkg::res_t results_due[$];
    int   err_count = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;

    logic [dgp_pkg::BYTE_W-1:0] blanks [4] =
        '{dgp_pkg::CH_SP, dgp_pkg::CH_TAB, dgp_pkg::CH_VT, dgp_pkg::CH_FF};

    // Directed items: reset defaults, extremes, terminators, comment drop, stream end
    stim_row_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, '{dgp_pkg::KIND_END, 16'hFFFF, 8'h00, 16'd0, 1'b0}},
        '{dgp_pkg::CH_TAB, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_MINUS, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_CR, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_LF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{dgp_pkg::KIND_VALUE, 16'h8000, 8'h00, 16'd0, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{dgp_pkg::KIND_VALUE, 16'h8000, 8'hFF, 16'd0, 1'b0}},
        '{dgp_pkg::CH_LF, 1'b0, 1'b1,
          '{dgp_pkg::KIND_RECORD, 16'h8000, 8'h00, 16'd2, 1'b0}},
        '{dgp_pkg::CH_CR, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_NINE, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_NINE, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_NINE, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_LF, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_LF, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_CR, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b1, '{dgp_pkg::KIND_END, 16'hFFFF, 8'h00, 16'd0, 1'b0}},
        '{dgp_pkg::CH_CR, 1'b0, 1'b0, '0},
        '{dgp_pkg::CH_CR, 1'b0, 1'b0, '0}
    };

    // Settings per phase: value_limit and skip_comments
    logic [dgp_pkg::LEN_W-1:0] phase_limit [NUM_PHASES] =
        '{16'd256, 16'd0, 16'hFFFF, 16'd3, 16'd1};
    logic             phase_skip  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int               phase_sidle [4] = '{0, 65, 0, 9};
    int               phase_rstall[4] = '{0, 0, 65, 9};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_parse();
        pr_phase   = LN_CODE;
        pr_accum   = '0;
        pr_neg     = 1'b0;
        pr_pstate  = PS_LEAD;
        pr_term    = TERM_NONE;
        pr_linelen = 0;
        pr_stored  = '0;
        pr_trunc   = 1'b0;
    endfunction

    // Signed 16-bit code of the pair so far, saturated
    function automatic logic [dgp_pkg::CODE_W-1:0] code_now();
        logic [dgp_pkg::ACC_W-1:0] neg;
        neg = 17'h10000 - pr_accum;
        if (pr_neg) return neg[dgp_pkg::CODE_W-1:0];
        if (pr_accum > {1'b0, dgp_pkg::CODE_POS_MAX}) return dgp_pkg::CODE_POS_MAX;
        return pr_accum[dgp_pkg::CODE_W-1:0];
    endfunction

    function automatic bit comment_pair();
        return cfg_skip && !pr_neg && (pr_accum == dgp_pkg::COMMENT_CODE);
    endfunction

    function automatic dgp_pkg::res_t mk_res(logic [dgp_pkg::KIND_W-1:0] k,
                                             logic [dgp_pkg::CODE_W-1:0] c,
                                             logic [dgp_pkg::BYTE_W-1:0] v,
                                             logic [dgp_pkg::LEN_W-1:0] l, logic t);
        dgp_pkg::res_t r;
        r.kind         = k;
        r.group_code   = c;
        r.value_byte   = v;
        r.value_length = l;
        r.truncated    = t;
        return r;
    endfunction

    // Advance the mirrored parser by one input item; returns 1 when it yields a result
    function automatic bit step_parser(input logic [dgp_pkg::BYTE_W-1:0] b, input logic eos,
                                       output dgp_pkg::res_t r);
        bit    was_halted;
        bit    drop;
        bit    is_digit;
        int    acc_next;
        term_t t;
        r = '0;
        if (eos) begin
            was_halted = (pr_phase == LN_HALTED);
            clear_parse();
            if (was_halted) return 1'b0;
            r = mk_res(dgp_pkg::KIND_END, 16'hFFFF, 8'h00, 16'd0, 1'b0);
            return 1'b1;
        end
        if (pr_phase == LN_HALTED) return 1'b0;

        // second half of a CRLF or LFCR pair is swallowed
        if (pr_term != TERM_NONE) begin
            t = pr_term;
            pr_term = TERM_NONE;
            if ((t == TERM_CR && b == dgp_pkg::CH_LF) ||
                (t == TERM_LF && b == dgp_pkg::CH_CR)) return 1'b0;
        end

        if (b == dgp_pkg::CH_CR || b == dgp_pkg::CH_LF) begin
            t = (b == dgp_pkg::CH_CR) ? TERM_CR : TERM_LF;
            if (pr_phase == LN_CODE) begin
                pr_phase   = LN_VALUE;
                pr_stored  = '0;
                pr_trunc   = 1'b0;
                pr_linelen = 0;
                pr_term    = t;
                return 1'b0;
            end
            drop = comment_pair();
            r = mk_res(dgp_pkg::KIND_RECORD, code_now(), 8'h00, pr_stored, pr_trunc);
            clear_parse();
            pr_term = t;
            return !drop;
        end

        if (pr_linelen >= LINE_MAX) begin
            pr_phase = LN_HALTED;
            r = mk_res(dgp_pkg::KIND_END, 16'hFFFF, 8'h00, 16'd0, 1'b0);
            return 1'b1;
        end
        pr_linelen++;

        // code line: atoi-style parse, no result
        if (pr_phase == LN_CODE) begin
            is_digit = (b >= dgp_pkg::CH_ZERO) && (b <= dgp_pkg::CH_NINE);
            if (pr_pstate == PS_LEAD &&
                (b == dgp_pkg::CH_SP || b == dgp_pkg::CH_TAB ||
                 b == dgp_pkg::CH_VT || b == dgp_pkg::CH_FF)) begin
                // leading blank, keep waiting
            end else if (pr_pstate == PS_LEAD && b == dgp_pkg::CH_PLUS) begin
                pr_pstate = PS_DIGITS;
            end else if (pr_pstate == PS_LEAD && b == dgp_pkg::CH_MINUS) begin
                pr_neg    = 1'b1;
                pr_pstate = PS_DIGITS;
            end else if (pr_pstate != PS_DONE && is_digit) begin
                pr_pstate = PS_DIGITS;
                acc_next  = int'(pr_accum) * 10 + int'(b - dgp_pkg::CH_ZERO);
                if (acc_next > int'(dgp_pkg::ACC_SAT)) acc_next = int'(dgp_pkg::ACC_SAT);
                pr_accum  = acc_next[dgp_pkg::ACC_W-1:0];
            end else begin
                pr_pstate = PS_DONE;
            end
            return 1'b0;
        end

        if (comment_pair()) return 1'b0;
        if (pr_stored < cfg_value_limit) begin
            pr_stored++;
            r = mk_res(dgp_pkg::KIND_VALUE, code_now(), b, 16'd0, 1'b0);
            return 1'b1;
        end
        pr_trunc = 1'b1;
        return 1'b0;
    endfunction

    // Offer one item, wait for the handshake, then record what it should produce
    task automatic send_byte(input logic [dgp_pkg::BYTE_W-1:0] b, input logic eos,
                             input bit typed = 1'b0, input dgp_pkg::res_t want = '0);
        dgp_pkg::res_t pred;
        bit            has;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        has = step_parser(b, eos, pred);
        if (typed) results_due.push_back(want);
        else if (has) results_due.push_back(pred);
    endtask

    // Sender goes quiet until every result is back, then lets the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [dgp_pkg::CFG_AW-1:0] addr,
                             input logic [dgp_pkg::CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_VALUE_LIMIT) cfg_value_limit = data[dgp_pkg::LEN_W-1:0];
        else cfg_skip = data[0];
        @(posedge aclk);
    endtask

    function automatic logic [dgp_pkg::BYTE_W-1:0] text_byte();
        logic [dgp_pkg::BYTE_W-1:0] b;
        b = 8'($urandom_range(255));
        if (b == dgp_pkg::CH_CR || b == dgp_pkg::CH_LF) b = b ^ 8'h80;
        return b;
    endfunction

    task automatic send_eol();
        case ($urandom_range(3))
            0: send_byte(dgp_pkg::CH_CR, 1'b0);
            1: send_byte(dgp_pkg::CH_LF, 1'b0);
            2: begin
                send_byte(dgp_pkg::CH_CR, 1'b0);
                send_byte(dgp_pkg::CH_LF, 1'b0);
            end
            default: begin
                send_byte(dgp_pkg::CH_LF, 1'b0);
                send_byte(dgp_pkg::CH_CR, 1'b0);
            end
        endcase
    endtask

    // Mostly well-formed pairs with random content, some noise and stream ends
    task automatic send_random_unit();
        int sel;
        int n;
        int k;
        sel = $urandom_range(99);
        if (sel < 4) begin
            send_byte(8'($urandom_range(255)), 1'b1);
        end else if (sel < 14) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else begin
            n = $urandom_range(2);
            for (k = 0; k < n; k++) send_byte(blanks[2'($urandom_range(3))], 1'b0);
            case ($urandom_range(3))
                0: send_byte(dgp_pkg::CH_PLUS, 1'b0);
                1: send_byte(dgp_pkg::CH_MINUS, 1'b0);
                default: ;
            endcase
            if ($urandom_range(3) == 0) begin
                for (k = 0; k < 3; k++) send_byte(dgp_pkg::CH_NINE, 1'b0);
            end else begin
                n = $urandom_range(6);
                for (k = 0; k < n; k++)
                    send_byte(dgp_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
            end
            if ($urandom_range(9) == 0) send_byte(text_byte(), 1'b0);
            send_eol();
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
            for (k = 0; k < n; k++) send_byte(text_byte(), 1'b0);
            send_eol();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge aclk) begin : result_check
        dgp_pkg::res_t got;
        dgp_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser;
            got.group_code   = m_tdata[15:0];
            got.value_byte   = m_tdata[23:16];
            got.value_length = m_tdata[39:24];
            got.truncated    = m_tdata[40];
            if (results_due.size() == 0) begin
                $error("unexpected result item: kind %0d code %0d", got.kind, got.group_code);
                err_count++;
            end else begin
                want = results_due.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    err_count++;
                end
                if (got.group_code !== want.group_code) begin
                    $error("group_code: expected %0d, got %0d", want.group_code, got.group_code);
                    err_count++;
                end
                if (got.value_byte !== want.value_byte) begin
                    $error("value_byte: expected %0d, got %0d", want.value_byte, got.value_byte);
                    err_count++;
                end
                if (got.value_length !== want.value_length) begin
                    $error("value_length: expected %0d, got %0d",
                           want.value_length, got.value_length);
                    err_count++;
                end
                if (got.truncated !== want.truncated) begin
                    $error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
                    err_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int  ph;
        int  start;
        bit  hold_done;
        bit  pause_done;
        cfg_value_limit = dgp_pkg::VALUE_LIMIT_RESET;
        cfg_skip        = dgp_pkg::SKIP_COMMENTS_RESET;
        clear_parse();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset configuration
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].eos,
                      directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // random phases, each with its own settings and an idle profile
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            apb_write(ADDR_VALUE_LIMIT, dgp_pkg::CFG_DW'(phase_limit[ph]));
            apb_write(ADDR_SKIP_COMMENTS, dgp_pkg::CFG_DW'(phase_skip[ph]));
            send_idle_pct  = phase_sidle[ph % 4];
            recv_stall_pct = phase_rstall[ph % 4];
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (ph == 0 && !hold_done && items_sent - start >= 30) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (ph == 1 && !pause_done && items_sent - start >= 45) begin
                    wait_drained();
                    pause_done = 1'b1;
                end
                send_random_unit();
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== dxf_ascii_group_pair_parser_top.f =====
+incdir+sv
sv/dgp_pkg.sv
sv/dgp_cfg.sv
sv/dgp_parse.sv
sv/dgp_outq.sv
sv/dxf_ascii_group_pair_parser_top.sv
tb/sv/dxf_ascii_group_pair_parser_top_tb.sv
